[hw/rtl/jcsm_pkg.sv]
`default_nettype none

package jcsm_pkg;

  localparam int SAMPLE_BITS_DEF = 12;
  localparam int PULSE_W         = 15;
  localparam int DEB_W           = 8;
  localparam int STEP_W          = 3;
  localparam int CFG_AW          = 4;
  localparam int CFG_DW          = 32;

  // Calibration step codes
  localparam logic [STEP_W-1:0] STEP_XMIN = 3'd0;
  localparam logic [STEP_W-1:0] STEP_XMAX = 3'd1;
  localparam logic [STEP_W-1:0] STEP_YMIN = 3'd2;
  localparam logic [STEP_W-1:0] STEP_YMAX = 3'd3;
  localparam logic [STEP_W-1:0] STEP_DONE = 3'd4;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_DEBOUNCE = 2'd0;
  localparam logic [1:0] REG_PMIN     = 2'd1;
  localparam logic [1:0] REG_PMAX     = 2'd2;
  localparam logic [1:0] REG_PCENTER  = 2'd3;

  localparam logic [DEB_W-1:0]   DEBOUNCE_RST = 8'd30;
  localparam logic [PULSE_W-1:0] PMIN_RST     = 15'd900;
  localparam logic [PULSE_W-1:0] PMAX_RST     = 15'd2100;
  localparam logic [PULSE_W-1:0] PCENTER_RST  = 15'd1500;

  typedef struct packed {
    logic               done;
    logic               fault;
    logic [PULSE_W-1:0] pulse;
  } lane_res_t;

  typedef struct packed {
    logic              calibrating;
    logic [STEP_W-1:0] step;
    logic              captured;
  } cal_tick_t;

endpackage

`default_nettype wire

[hw/rtl/jcsm_in_if.sv]
`default_nettype none

interface jcsm_in_if #(
  parameter int SAMPLE_BITS = jcsm_pkg::SAMPLE_BITS_DEF
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample_x;
  logic [SAMPLE_BITS-1:0] sample_y;
  logic                   button_n;

  modport source (output valid, output sample_x, output sample_y, output button_n,
                  input ready);
  modport sink   (input valid, input sample_x, input sample_y, input button_n,
                  output ready);
endinterface

`default_nettype wire

[hw/rtl/jcsm_out_if.sv]
`default_nettype none

interface jcsm_out_if #(
  parameter int SAMPLE_BITS = jcsm_pkg::SAMPLE_BITS_DEF
);
  logic                            valid;
  logic                            ready;
  logic                            calibrating;
  logic [jcsm_pkg::STEP_W-1:0]     cal_step;
  logic [SAMPLE_BITS-1:0]          live_value;
  logic                            captured;
  logic [jcsm_pkg::PULSE_W-1:0]    pulse_x_us;
  logic [jcsm_pkg::PULSE_W-1:0]    pulse_y_us;
  logic                            range_fault;

  modport source (output valid, output calibrating, output cal_step, output live_value,
                  output captured, output pulse_x_us, output pulse_y_us,
                  output range_fault, input ready);
  modport sink   (input valid, input calibrating, input cal_step, input live_value,
                  input captured, input pulse_x_us, input pulse_y_us,
                  input range_fault, output ready);
endinterface

`default_nettype wire

[hw/rtl/jcsm_cal_ctrl.sv]
`default_nettype none

module jcsm_cal_ctrl #(
  parameter int SAMPLE_BITS = jcsm_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          tick,
  input  logic [SAMPLE_BITS-1:0]        sample_x,
  input  logic [SAMPLE_BITS-1:0]        sample_y,
  input  logic                          button_n,
  input  logic [jcsm_pkg::DEB_W-1:0]    debounce_limit,
  output jcsm_pkg::cal_tick_t           info,
  output logic [SAMPLE_BITS-1:0]        live_value,
  output logic [SAMPLE_BITS-1:0]        x_low,
  output logic [SAMPLE_BITS-1:0]        x_high,
  output logic [SAMPLE_BITS-1:0]        y_low,
  output logic [SAMPLE_BITS-1:0]        y_high
);

  logic [jcsm_pkg::STEP_W-1:0] step_r, step_nxt;
  logic [SAMPLE_BITS-1:0]      xlo_r, xlo_nxt, xhi_r, xhi_nxt;
  logic [SAMPLE_BITS-1:0]      ylo_r, ylo_nxt, yhi_r, yhi_nxt;
  logic [jcsm_pkg::DEB_W-1:0]  pc_r, pc_nxt, rc_r, rc_nxt;
  logic [jcsm_pkg::DEB_W-1:0]  pc_inc, rc_inc;
  logic                        latched_r, latched_nxt;
  logic                        calibrating;
  logic                        cap;
  logic [SAMPLE_BITS-1:0]      live;

  assign calibrating = (step_r < jcsm_pkg::STEP_DONE);
  assign live = (step_r == jcsm_pkg::STEP_XMIN || step_r == jcsm_pkg::STEP_XMAX) ?
                sample_x : sample_y;
  assign pc_inc = pc_r + 1'b1;
  assign rc_inc = rc_r + 1'b1;

  always_comb begin
    step_nxt    = step_r;
    xlo_nxt     = xlo_r;
    xhi_nxt     = xhi_r;
    ylo_nxt     = ylo_r;
    yhi_nxt     = yhi_r;
    pc_nxt      = pc_r;
    rc_nxt      = rc_r;
    latched_nxt = latched_r;
    cap         = 1'b0;
    if (tick && calibrating) begin
      if (!button_n) begin
        pc_nxt = pc_inc;
        if (pc_inc > debounce_limit && !latched_r) begin
          case (step_r)
            jcsm_pkg::STEP_XMIN: xlo_nxt = live;
            jcsm_pkg::STEP_XMAX: xhi_nxt = live;
            jcsm_pkg::STEP_YMIN: ylo_nxt = live;
            default:             yhi_nxt = live;
          endcase
          step_nxt    = step_r + 1'b1;
          pc_nxt      = '0;
          rc_nxt      = '0;
          latched_nxt = 1'b1;
          cap         = 1'b1;
        end
      end else begin
        // The press counter is deliberately left alone on release.
        rc_nxt = rc_inc;
        if (rc_inc > debounce_limit) begin
          latched_nxt = 1'b0;
          rc_nxt      = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r    <= jcsm_pkg::STEP_XMIN;
      xlo_r     <= '0;
      xhi_r     <= '0;
      ylo_r     <= '0;
      yhi_r     <= '0;
      pc_r      <= '0;
      rc_r      <= '0;
      latched_r <= 1'b0;
    end else begin
      step_r    <= step_nxt;
      xlo_r     <= xlo_nxt;
      xhi_r     <= xhi_nxt;
      ylo_r     <= ylo_nxt;
      yhi_r     <= yhi_nxt;
      pc_r      <= pc_nxt;
      rc_r      <= rc_nxt;
      latched_r <= latched_nxt;
    end
  end

  assign info.calibrating = calibrating;
  assign info.step        = step_r;
  assign info.captured    = cap;
  assign live_value       = calibrating ? live : '0;
  assign x_low            = xlo_r;
  assign x_high           = xhi_r;
  assign y_low            = ylo_r;
  assign y_high           = yhi_r;

endmodule

`default_nettype wire

[hw/rtl/jcsm_axis_lane.sv]
`default_nettype none

module jcsm_axis_lane #(
  parameter int SAMPLE_BITS = jcsm_pkg::SAMPLE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [SAMPLE_BITS-1:0]       sample,
  input  logic [SAMPLE_BITS-1:0]       cal_low,
  input  logic [SAMPLE_BITS-1:0]       cal_high,
  input  logic [jcsm_pkg::PULSE_W-1:0] pulse_min_us,
  input  logic [jcsm_pkg::PULSE_W-1:0] pulse_max_us,
  input  logic [jcsm_pkg::PULSE_W-1:0] pulse_center_us,
  output jcsm_pkg::lane_res_t          res
);

  localparam int PW    = jcsm_pkg::PULSE_W;
  localparam int MAG_W = SAMPLE_BITS + PW;
  localparam int CNT_W = $clog2(MAG_W);
  localparam int SUM_W = MAG_W + 2;

  localparam logic [1:0] LS_IDLE = 2'd0;
  localparam logic [1:0] LS_MUL  = 2'd1;
  localparam logic [1:0] LS_DIV  = 2'd2;
  localparam logic [1:0] LS_FIN  = 2'd3;

  logic [1:0]             st_r;
  logic [CNT_W-1:0]       cnt_r;
  logic [SAMPLE_BITS-1:0] a_mag_r, d_mag_r, rem_r;
  logic [PW-1:0]          b_mag_r;
  logic                   neg_r, zero_r;
  logic [MAG_W-1:0]       quo_r;
  logic                   done_r, fault_r;
  logic [PW-1:0]          pulse_r;

  // Magnitudes and signs of the three differences.
  logic [SAMPLE_BITS:0]   diff_a, neg_a, diff_d, neg_d, shifted, trial;
  logic [PW:0]            diff_b, neg_b;
  logic [SAMPLE_BITS-1:0] a_mag, d_mag;
  logic [PW-1:0]          b_mag;
  logic                   ge;

  logic [MAG_W:0]           q_pos, q_sgn;
  logic signed [SUM_W-1:0]  sum, lo_ext, hi_ext;
  logic [PW-1:0]            lim_lo, lim_hi, clamped;

  assign diff_a = {1'b0, sample} - {1'b0, cal_low};
  assign neg_a  = -diff_a;
  assign a_mag  = diff_a[SAMPLE_BITS] ? neg_a[SAMPLE_BITS-1:0] : diff_a[SAMPLE_BITS-1:0];
  assign diff_d = {1'b0, cal_high} - {1'b0, cal_low};
  assign neg_d  = -diff_d;
  assign d_mag  = diff_d[SAMPLE_BITS] ? neg_d[SAMPLE_BITS-1:0] : diff_d[SAMPLE_BITS-1:0];
  assign diff_b = {1'b0, pulse_max_us} - {1'b0, pulse_min_us};
  assign neg_b  = -diff_b;
  assign b_mag  = diff_b[PW] ? neg_b[PW-1:0] : diff_b[PW-1:0];

  // One restoring step per cycle.
  assign shifted = {rem_r, quo_r[MAG_W-1]};
  assign trial   = shifted - {1'b0, d_mag_r};
  assign ge      = !trial[SAMPLE_BITS];

  // Truncated quotient gets its sign back, is offset by the minimum pulse and clamped.
  assign q_pos   = {1'b0, quo_r};
  assign q_sgn   = neg_r ? -q_pos : q_pos;
  assign sum     = $signed({q_sgn[MAG_W], q_sgn}) +
                   $signed({{(SUM_W-PW){1'b0}}, pulse_min_us});
  assign lim_lo  = (pulse_min_us < pulse_max_us) ? pulse_min_us : pulse_max_us;
  assign lim_hi  = (pulse_min_us < pulse_max_us) ? pulse_max_us : pulse_min_us;
  assign lo_ext  = $signed({{(SUM_W-PW){1'b0}}, lim_lo});
  assign hi_ext  = $signed({{(SUM_W-PW){1'b0}}, lim_hi});

  always_comb begin
    if (sum < lo_ext) begin
      clamped = lim_lo;
    end else if (sum > hi_ext) begin
      clamped = lim_hi;
    end else begin
      clamped = sum[PW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= LS_IDLE;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (st_r)
        LS_IDLE: begin
          if (start) begin
            st_r <= LS_MUL;
          end
        end
        LS_MUL: begin
          st_r <= LS_DIV;
        end
        LS_DIV: begin
          if (cnt_r == '0) begin
            st_r <= LS_FIN;
          end
        end
        LS_FIN: begin
          done_r <= 1'b1;
          st_r   <= LS_IDLE;
        end
        default: st_r <= LS_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (st_r)
      LS_IDLE: begin
        if (start) begin
          a_mag_r <= a_mag;
          b_mag_r <= b_mag;
          d_mag_r <= d_mag;
          // The quotient is negative when an odd number of the three differences are.
          neg_r   <= diff_a[SAMPLE_BITS] ^ diff_b[PW] ^ diff_d[SAMPLE_BITS];
          zero_r  <= (cal_high == cal_low);
        end
      end
      LS_MUL: begin
        quo_r <= MAG_W'(a_mag_r * b_mag_r);
        rem_r <= '0;
        cnt_r <= CNT_W'(MAG_W - 1);
      end
      LS_DIV: begin
        if (ge) begin
          rem_r <= trial[SAMPLE_BITS-1:0];
        end else begin
          rem_r <= shifted[SAMPLE_BITS-1:0];
        end
        quo_r <= {quo_r[MAG_W-2:0], ge};
        cnt_r <= cnt_r - 1'b1;
      end
      LS_FIN: begin
        fault_r <= zero_r;
        pulse_r <= zero_r ? pulse_center_us : clamped;
      end
      default: ;
    endcase
  end

  assign res.done  = done_r;
  assign res.fault = fault_r;
  assign res.pulse = pulse_r;

endmodule

`default_nettype wire

[hw/rtl/joystick_calibrate_servo_map_unit.sv]
`default_nettype none

// Joystick calibration and two-axis servo mapper. Items are handled one at a
// time. Until four calibration captures (X low, X high, Y low, Y high) have
// been taken by debounced presses, a transaction carries centre pulses and its
// result is registered as pending and then moved into the output register.
// After that, each transaction is mapped by two axis lanes running side by
// side: a product step, a bit-serial restoring divider that produces one
// quotient bit per cycle, and a clamp step, after which the result is handed
// over to the output register. The next input is accepted as soon as the
// result has moved into the output register, even if it has not yet been
// taken; a result still waiting there holds the next one back. Configuration
// registers on the APB port: debounce limit at 0x0, minimum pulse at 0x4,
// maximum pulse at 0x8, centre pulse at 0xC.
module joystick_calibrate_servo_map_unit #(
  parameter int SAMPLE_BITS = jcsm_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  jcsm_in_if.sink                       in_ch,
  jcsm_out_if.source                    out_ch,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [jcsm_pkg::CFG_AW-1:0]   paddr,
  input  logic [jcsm_pkg::CFG_DW-1:0]   pwdata,
  output logic [jcsm_pkg::CFG_DW-1:0]   prdata,
  output logic                          pready
);

  localparam int PW = jcsm_pkg::PULSE_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_BUSY = 2'd1;
  localparam logic [1:0] ST_PEND = 2'd2;

  logic [jcsm_pkg::DEB_W-1:0] debounce_r;
  logic [PW-1:0]              pmin_r, pmax_r, pcenter_r;
  logic                       cfg_wr;
  logic [1:0]                 cfg_idx;

  logic [1:0]                 st_r;
  logic                       in_fire, out_fire, load_out;

  jcsm_pkg::cal_tick_t        cal_info;
  logic [SAMPLE_BITS-1:0]     cal_live, x_low, x_high, y_low, y_high;
  jcsm_pkg::lane_res_t        x_res, y_res;
  logic                       lane_start;

  // Pending result
  logic                       res_cal_r, res_cap_r, res_fault_r;
  logic [jcsm_pkg::STEP_W-1:0] res_step_r;
  logic [SAMPLE_BITS-1:0]     res_live_r;
  logic [PW-1:0]              res_px_r, res_py_r;

  // Output register
  logic                       out_valid_r, out_cal_r, out_cap_r, out_fault_r;
  logic [jcsm_pkg::STEP_W-1:0] out_step_r;
  logic [SAMPLE_BITS-1:0]     out_live_r;
  logic [PW-1:0]              out_px_r, out_py_r;

  // Configuration port
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r <= jcsm_pkg::DEBOUNCE_RST;
      pmin_r     <= jcsm_pkg::PMIN_RST;
      pmax_r     <= jcsm_pkg::PMAX_RST;
      pcenter_r  <= jcsm_pkg::PCENTER_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        jcsm_pkg::REG_DEBOUNCE: debounce_r <= pwdata[jcsm_pkg::DEB_W-1:0];
        jcsm_pkg::REG_PMIN:     pmin_r     <= pwdata[PW-1:0];
        jcsm_pkg::REG_PMAX:     pmax_r     <= pwdata[PW-1:0];
        jcsm_pkg::REG_PCENTER:  pcenter_r  <= pwdata[PW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      jcsm_pkg::REG_DEBOUNCE: prdata = {{(jcsm_pkg::CFG_DW-jcsm_pkg::DEB_W){1'b0}}, debounce_r};
      jcsm_pkg::REG_PMIN:     prdata = {{(jcsm_pkg::CFG_DW-PW){1'b0}}, pmin_r};
      jcsm_pkg::REG_PMAX:     prdata = {{(jcsm_pkg::CFG_DW-PW){1'b0}}, pmax_r};
      jcsm_pkg::REG_PCENTER:  prdata = {{(jcsm_pkg::CFG_DW-PW){1'b0}}, pcenter_r};
      default:                prdata = '0;
    endcase
  end

  // Handshakes
  assign in_ch.ready = (st_r == ST_IDLE);
  assign in_fire     = in_ch.valid && (st_r == ST_IDLE);
  assign out_fire    = out_valid_r && out_ch.ready;
  assign load_out    = (st_r == ST_PEND) && (!out_valid_r || out_ch.ready);
  assign lane_start  = in_fire && !cal_info.calibrating;

  jcsm_cal_ctrl #(.SAMPLE_BITS(SAMPLE_BITS)) u_cal (
    .clk            (clk),
    .rst_n          (rst_n),
    .tick           (in_fire),
    .sample_x       (in_ch.sample_x),
    .sample_y       (in_ch.sample_y),
    .button_n       (in_ch.button_n),
    .debounce_limit (debounce_r),
    .info           (cal_info),
    .live_value     (cal_live),
    .x_low          (x_low),
    .x_high         (x_high),
    .y_low          (y_low),
    .y_high         (y_high)
  );

  jcsm_axis_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_x (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (lane_start),
    .sample          (in_ch.sample_x),
    .cal_low         (x_low),
    .cal_high        (x_high),
    .pulse_min_us    (pmin_r),
    .pulse_max_us    (pmax_r),
    .pulse_center_us (pcenter_r),
    .res             (x_res)
  );

  jcsm_axis_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_y (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (lane_start),
    .sample          (in_ch.sample_y),
    .cal_low         (y_low),
    .cal_high        (y_high),
    .pulse_min_us    (pmin_r),
    .pulse_max_us    (pmax_r),
    .pulse_center_us (pcenter_r),
    .res             (y_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
    end else begin
      unique case (st_r)
        ST_IDLE: begin
          if (in_fire) begin
            st_r <= cal_info.calibrating ? ST_PEND : ST_BUSY;
          end
        end
        ST_BUSY: begin
          if (x_res.done) begin
            st_r <= ST_PEND;
          end
        end
        ST_PEND: begin
          if (load_out) begin
            st_r <= ST_IDLE;
          end
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end

  // Pending result: calibration ticks straight from the controller, control
  // ticks when both lanes report (they run in lockstep).
  always_ff @(posedge clk) begin
    if (in_fire) begin
      res_cal_r   <= cal_info.calibrating;
      res_step_r  <= cal_info.step;
      res_live_r  <= cal_live;
      res_cap_r   <= cal_info.captured;
      res_px_r    <= pcenter_r;
      res_py_r    <= pcenter_r;
      res_fault_r <= 1'b0;
    end else if (st_r == ST_BUSY && x_res.done) begin
      res_px_r    <= x_res.pulse;
      res_py_r    <= y_res.pulse;
      res_fault_r <= x_res.fault || y_res.fault;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_fire) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_cal_r   <= res_cal_r;
      out_step_r  <= res_step_r;
      out_live_r  <= res_live_r;
      out_cap_r   <= res_cap_r;
      out_px_r    <= res_px_r;
      out_py_r    <= res_py_r;
      out_fault_r <= res_fault_r;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.calibrating = out_cal_r;
  assign out_ch.cal_step    = out_step_r;
  assign out_ch.live_value  = out_live_r;
  assign out_ch.captured    = out_cap_r;
  assign out_ch.pulse_x_us  = out_px_r;
  assign out_ch.pulse_y_us  = out_py_r;
  assign out_ch.range_fault = out_fault_r;

`ifndef NO_ASSERTIONS
  a_lanes_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    x_res.done == y_res.done)
    else $error("axis lanes finished in different cycles");

  a_done_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    x_res.done |-> st_r == ST_BUSY)
    else $error("lane result arrived outside a mapping transaction");

  a_start_maps: assert property (@(posedge clk) disable iff (!rst_n)
    lane_start |=> st_r == ST_BUSY)
    else $error("control transaction did not start the lanes");

  a_capture_in_cal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_cap_r |-> out_cal_r)
    else $error("capture reported outside calibration");

  a_fault_in_ctrl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_fault_r |-> !out_cal_r)
    else $error("range fault reported during calibration");
`endif

endmodule

`default_nettype wire

[tb/joystick_calibrate_servo_map_unit_tb.sv]
module joystick_calibrate_servo_map_unit_tb;

  localparam int SB = jcsm_pkg::SAMPLE_BITS_DEF;
  localparam int PW = jcsm_pkg::PULSE_W;
  localparam int SW = jcsm_pkg::STEP_W;

  localparam int          N_PHASE     = 8;
  localparam int          HOLD_PHASE  = 5;
  localparam int          PHASE_TICKS = 190;
  localparam int          HOLD_CYCLES = 300;
  localparam int          TAIL_CYCLES = 80;
  localparam int unsigned CYCLE_LIMIT = 1000000;

  typedef struct packed {
    logic          calibrating;
    logic [SW-1:0] step;
    logic [SB-1:0] live;
    logic          captured;
    logic [PW-1:0] px;
    logic [PW-1:0] py;
    logic          fault;
  } tick_res_t;

  typedef struct {
    bit            is_cfg;
    logic [1:0]    reg_idx;
    int            value;
    logic [SB-1:0] sx;
    logic [SB-1:0] sy;
    logic          bn;
    bit            aim;
    bit            typed;
    tick_res_t     want;
  } plan_row_t;

  logic clk;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [jcsm_pkg::CFG_AW-1:0] paddr;
  logic [jcsm_pkg::CFG_DW-1:0] pwdata;
  logic [jcsm_pkg::CFG_DW-1:0] prdata;
  logic pready;

  jcsm_in_if  #(.SAMPLE_BITS(SB)) in_ch ();
  jcsm_out_if #(.SAMPLE_BITS(SB)) out_ch ();

  joystick_calibrate_servo_map_unit #(.SAMPLE_BITS(SB)) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Mirror of the block's settings and calibration state.
  logic [jcsm_pkg::DEB_W-1:0] deb_lim;
  logic [PW-1:0]    pmin_us;
  logic [PW-1:0]    pmax_us;
  logic [PW-1:0]    pcen_us;
  logic [SW-1:0]    cal_stage;
  logic [SB-1:0]    axis_lo [2];
  logic [SB-1:0]    axis_hi [2];
  logic [7:0]       n_press;
  logic [7:0]       n_release;
  logic             latched;

  tick_res_t pending_ticks [$];
  plan_row_t plan [$];
  int        cal_target [4];

  int unsigned cycles;
  int n_fail, n_ticks, n_cal, n_caps, n_faults;
  bit quiet;
  bit hold_req;
  int hold_left;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin : watchdog
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  function automatic logic [PW-1:0] axis_pulse(input int v, input int lo, input int hi,
                                               output bit zero);
    longint r, c_lo, c_hi;
    zero = (hi == lo);
    if (zero) return pcen_us;
    r = longint'(pmin_us)
        + (longint'(v - lo) * (longint'(pmax_us) - longint'(pmin_us))) / longint'(hi - lo);
    c_lo = (pmin_us < pmax_us) ? longint'(pmin_us) : longint'(pmax_us);
    c_hi = (pmin_us < pmax_us) ? longint'(pmax_us) : longint'(pmin_us);
    if (r < c_lo) r = c_lo;
    if (r > c_hi) r = c_hi;
    return r[PW-1:0];
  endfunction

  function automatic tick_res_t servo_predict(input logic [SB-1:0] sx, input logic [SB-1:0] sy,
                                              input logic bn);
    tick_res_t r;
    logic [SB-1:0] live;
    bit zero_x, zero_y;
    r = '0;
    r.step = cal_stage;
    r.px = pcen_us;
    r.py = pcen_us;
    if (cal_stage < jcsm_pkg::STEP_DONE) begin
      r.calibrating = 1'b1;
      live = (cal_stage < jcsm_pkg::STEP_YMIN) ? sx : sy;
      r.live = live;
      if (!bn) begin
        n_press = n_press + 8'd1;
        if (n_press > deb_lim && !latched) begin
          case (cal_stage)
            jcsm_pkg::STEP_XMIN: axis_lo[0] = live;
            jcsm_pkg::STEP_XMAX: axis_hi[0] = live;
            jcsm_pkg::STEP_YMIN: axis_lo[1] = live;
            default:             axis_hi[1] = live;
          endcase
          cal_stage = cal_stage + 1'b1;
          n_press = '0;
          n_release = '0;
          latched = 1'b1;
          r.captured = 1'b1;
        end
      end else begin
        n_release = n_release + 8'd1;
        if (n_release > deb_lim) begin
          latched = 1'b0;
          n_release = '0;
        end
      end
    end else begin
      r.px = axis_pulse(int'(sx), int'(axis_lo[0]), int'(axis_hi[0]), zero_x);
      r.py = axis_pulse(int'(sy), int'(axis_lo[1]), int'(axis_hi[1]), zero_y);
      r.fault = zero_x | zero_y;
    end
    return r;
  endfunction

  function automatic tick_res_t cal_want(input logic [SW-1:0] step, input int live,
                                         input int pulse);
    tick_res_t r;
    r = '0;
    r.calibrating = 1'b1;
    r.step = step;
    r.live = SB'(live);
    r.px = PW'(pulse);
    r.py = PW'(pulse);
    return r;
  endfunction

  function automatic void add_tick(input int sx, input int sy, input logic bn, input bit aim,
                                   input bit typed, input tick_res_t want);
    plan_row_t r;
    r.is_cfg = 1'b0;
    r.reg_idx = jcsm_pkg::REG_DEBOUNCE;
    r.value = 0;
    r.sx = SB'(sx);
    r.sy = SB'(sy);
    r.bn = bn;
    r.aim = aim;
    r.typed = typed;
    r.want = want;
    plan.push_back(r);
  endfunction

  function automatic void add_cfg(input logic [1:0] idx, input int val);
    plan_row_t r;
    r.is_cfg = 1'b1;
    r.reg_idx = idx;
    r.value = val;
    r.sx = '0;
    r.sy = '0;
    r.bn = 1'b1;
    r.aim = 1'b0;
    r.typed = 1'b0;
    r.want = '0;
    plan.push_back(r);
  endfunction

  function automatic logic [31:0] reg_value(input logic [1:0] idx);
    case (idx)
      jcsm_pkg::REG_DEBOUNCE: return 32'(deb_lim);
      jcsm_pkg::REG_PMIN:     return 32'(pmin_us);
      jcsm_pkg::REG_PMAX:     return 32'(pmax_us);
      default:                return 32'(pcen_us);
    endcase
  endfunction

  function automatic int idle_len();
    int r;
    r = $urandom_range(99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic int sender_gap();
    if ($urandom_range(99) < 55) return 0;
    return idle_len();
  endfunction

  function automatic logic [SB-1:0] rand_sample();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return SB'($urandom_range(4095));
    endcase
  endfunction

  // Samples near the calibrated ends and beyond them, so that clamping is hit often.
  function automatic logic [SB-1:0] pick_sample(input int lo, input int hi);
    case ($urandom_range(11))
      0:       return '0;
      1:       return '1;
      2:       return SB'(lo);
      3:       return SB'(hi);
      4:       return SB'(lo + 1);
      5:       return SB'(hi - 1);
      default: return SB'($urandom_range(4095));
    endcase
  endfunction

  // A pressed tick may be the one that captures, so it carries the planned value.
  function automatic void aim_capture(inout logic [SB-1:0] sx, inout logic [SB-1:0] sy);
    if (cal_stage < jcsm_pkg::STEP_DONE) begin
      if (cal_stage < jcsm_pkg::STEP_YMIN) sx = SB'(cal_target[int'(cal_stage)]);
      else sy = SB'(cal_target[int'(cal_stage)]);
    end
  endfunction

  task automatic field_chk(input string what, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      n_fail++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
    end
  endtask

  task automatic apb_xfer(input logic [1:0] idx, input bit wr, input logic [31:0] wdata,
                          output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    // The bus is left idle with psel dropped before the next transfer.
    @(posedge clk);
  endtask

  task automatic reg_check(input logic [1:0] idx);
    logic [31:0] rd;
    apb_xfer(idx, 1'b0, '0, rd);
    field_chk($sformatf("register %0d readback", idx), reg_value(idx), rd);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input int val);
    logic [31:0] rd;
    apb_xfer(idx, 1'b1, 32'(val), rd);
    case (idx)
      jcsm_pkg::REG_DEBOUNCE: deb_lim = jcsm_pkg::DEB_W'(val);
      jcsm_pkg::REG_PMIN:     pmin_us = PW'(val);
      jcsm_pkg::REG_PMAX:     pmax_us = PW'(val);
      default:                pcen_us = PW'(val);
    endcase
    reg_check(idx);
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    while (pending_ticks.size() != 0) @(posedge clk);
  endtask

  task automatic offer_tick(input logic [SB-1:0] sx, input logic [SB-1:0] sy, input logic bn,
                            input bit typed, input tick_res_t want);
    tick_res_t model;
    int gap;
    in_ch.valid    <= 1'b1;
    in_ch.sample_x <= sx;
    in_ch.sample_y <= sy;
    in_ch.button_n <= bn;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    model = servo_predict(sx, sy, bn);
    pending_ticks.push_back(typed ? want : model);
    n_ticks++;
    if (model.calibrating) n_cal++;
    if (model.captured) n_caps++;
    if (model.fault) n_faults++;
    gap = quiet ? 0 : sender_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  initial begin : result_sink
    tick_res_t got, want;
    int stall_left;
    stall_left = 0;
    hold_left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        got.calibrating = out_ch.calibrating;
        got.step        = out_ch.cal_step;
        got.live        = out_ch.live_value;
        got.captured    = out_ch.captured;
        got.px          = out_ch.pulse_x_us;
        got.py          = out_ch.pulse_y_us;
        got.fault       = out_ch.range_fault;
        if (pending_ticks.size() == 0) begin
          n_fail++;
          if (n_fail <= 40) $display("%0t: result transaction with nothing expected", $time);
        end else begin
          want = pending_ticks.pop_front();
          field_chk("calibrating", want.calibrating, got.calibrating);
          field_chk("cal_step", want.step, got.step);
          field_chk("live_value", want.live, got.live);
          field_chk("captured", want.captured, got.captured);
          field_chk("pulse_x_us", want.px, got.px);
          field_chk("pulse_y_us", want.py, got.py);
          field_chk("range_fault", want.fault, got.fault);
        end
      end
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if (!quiet && $urandom_range(5) == 0) stall_left = idle_len();
      end
    end
  end

  initial begin : stimulus
    logic [SB-1:0] sx, sy;
    logic bn;
    bit pressing;
    int run, zero_axis, mapped, a, b, z, ph;
    int ph_min [N_PHASE];
    int ph_max [N_PHASE];
    int ph_cen [N_PHASE];

    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_ch.valid = 1'b0;
    in_ch.sample_x = '0;
    in_ch.sample_y = '0;
    in_ch.button_n = 1'b1;
    quiet = 1'b0;
    hold_req = 1'b0;
    n_fail = 0;
    n_ticks = 0;
    n_cal = 0;
    n_caps = 0;
    n_faults = 0;

    deb_lim = jcsm_pkg::DEBOUNCE_RST;
    pmin_us = jcsm_pkg::PMIN_RST;
    pmax_us = jcsm_pkg::PMAX_RST;
    pcen_us = jcsm_pkg::PCENTER_RST;
    cal_stage = jcsm_pkg::STEP_XMIN;
    axis_lo = '{default: '0};
    axis_hi = '{default: '0};
    n_press = '0;
    n_release = '0;
    latched = 1'b0;

    // One axis is calibrated onto a zero span; the other gets two distinct ends in
    // random order, kept away from the sample limits so that clamping is reached.
    zero_axis = $urandom_range(1);
    mapped = 1 - zero_axis;
    a = $urandom_range(100, 3995);
    do b = $urandom_range(100, 3995); while (b == a);
    z = $urandom_range(4095);
    cal_target[2 * mapped] = a;
    cal_target[2 * mapped + 1] = b;
    cal_target[2 * zero_axis] = z;
    cal_target[2 * zero_axis + 1] = z;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int i = int'(jcsm_pkg::REG_DEBOUNCE); i <= int'(jcsm_pkg::REG_PCENTER); i++)
      reg_check(2'(i));

    add_tick(0, 4095, 1'b1, 1'b0, 1'b1,
             cal_want(jcsm_pkg::STEP_XMIN, 0, jcsm_pkg::PCENTER_RST));
    add_tick(4095, 0, 1'b0, 1'b0, 1'b1,
             cal_want(jcsm_pkg::STEP_XMIN, 4095, jcsm_pkg::PCENTER_RST));
    add_cfg(jcsm_pkg::REG_DEBOUNCE, 255);
    add_tick(12'hAAA, 12'h555, 1'b0, 1'b0, 1'b1,
             cal_want(jcsm_pkg::STEP_XMIN, 12'hAAA, jcsm_pkg::PCENTER_RST));
    add_tick(12'h555, 12'hAAA, 1'b0, 1'b0, 1'b1,
             cal_want(jcsm_pkg::STEP_XMIN, 12'h555, jcsm_pkg::PCENTER_RST));
    add_tick(12'hFFF, 12'hFFF, 1'b0, 1'b0, 1'b1,
             cal_want(jcsm_pkg::STEP_XMIN, 12'hFFF, jcsm_pkg::PCENTER_RST));
    add_cfg(jcsm_pkg::REG_PCENTER, 0);
    add_tick(12'h800, 12'h001, 1'b1, 1'b0, 1'b1, cal_want(jcsm_pkg::STEP_XMIN, 12'h800, 0));
    add_cfg(jcsm_pkg::REG_PCENTER, 20000);
    add_tick(12'h001, 12'h800, 1'b1, 1'b0, 1'b1, cal_want(jcsm_pkg::STEP_XMIN, 12'h001, 20000));
    // With no debounce margin the next press captures at once, the one after is
    // held off by the latch, and a single release frees it again.
    add_cfg(jcsm_pkg::REG_DEBOUNCE, 0);
    add_tick(0, 4095, 1'b0, 1'b1, 1'b0, '0);
    add_tick(4095, 0, 1'b0, 1'b1, 1'b0, '0);
    add_tick(12'h123, 12'hEDC, 1'b1, 1'b0, 1'b1, cal_want(jcsm_pkg::STEP_XMAX, 12'h123, 20000));
    add_tick(0, 0, 1'b0, 1'b1, 1'b0, '0);
    add_cfg(jcsm_pkg::REG_PCENTER, 1500);

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        settle();
        cfg_write(plan[i].reg_idx, plan[i].value);
      end else begin
        sx = plan[i].sx;
        sy = plan[i].sy;
        if (plan[i].aim) aim_capture(sx, sy);
        offer_tick(sx, sy, plan[i].bn, plan[i].typed, plan[i].want);
      end
    end

    // The Y captures come from bouncy presses and releases of random length.
    settle();
    cfg_write(jcsm_pkg::REG_DEBOUNCE, $urandom_range(1, 6));
    pressing = 1'b1;
    run = $urandom_range(1, int'(deb_lim) + 4);
    while (cal_stage < jcsm_pkg::STEP_DONE) begin
      sx = rand_sample();
      sy = rand_sample();
      bn = !pressing;
      if ($urandom_range(7) == 0) bn = !bn;
      if (!bn) aim_capture(sx, sy);
      offer_tick(sx, sy, bn, 1'b0, '0);
      run--;
      if (run == 0) begin
        pressing = !pressing;
        run = $urandom_range(1, int'(deb_lim) + 4);
      end
    end

    ph_min = '{900, 0, 20000, 7000, 0, 0, 0, 0};
    ph_max = '{2100, 20000, 0, 7000, 0, 0, 0, 0};
    ph_cen = '{1500, 20000, 0, 123, 0, 0, 0, 0};
    for (int i = 4; i < N_PHASE; i++) begin
      ph_min[i] = $urandom_range(20000);
      ph_max[i] = $urandom_range(20000);
      ph_cen[i] = $urandom_range(20000);
    end

    for (ph = 0; ph < N_PHASE; ph++) begin
      settle();
      quiet = 1'b0;
      cfg_write(jcsm_pkg::REG_PMIN, ph_min[ph]);
      cfg_write(jcsm_pkg::REG_PMAX, ph_max[ph]);
      cfg_write(jcsm_pkg::REG_PCENTER, ph_cen[ph]);
      quiet = (ph == 1 || ph == HOLD_PHASE);
      // The sink stops for a long stretch while items keep coming, so the block backs up.
      if (ph == HOLD_PHASE) hold_req = 1'b1;
      repeat (PHASE_TICKS) begin
        sx = pick_sample(int'(axis_lo[0]), int'(axis_hi[0]));
        sy = pick_sample(int'(axis_lo[1]), int'(axis_hi[1]));
        offer_tick(sx, sy, 1'($urandom_range(1)), 1'b0, '0);
      end
    end

    settle();
    quiet = 1'b0;
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Run covered %0d ticks: %0d during calibration with %0d captures, %0d mapped.",
             n_ticks, n_cal, n_caps, n_ticks - n_cal);
    $display("Mapping ran under %0d pulse settings; the %s axis had a zero span (%0d faults).",
             N_PHASE, (zero_axis == 0) ? "X" : "Y", n_faults);
    if (n_fail == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
